/* rtl/mrb_pkg.sv */
// Shared types, constants and result codes for the message reorder buffer.
package mrb_pkg;

    localparam int WINDOW_DEFAULT = 64;
    localparam int MAX_RESULTS    = 64;
    localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int LIMIT_W        = 6;
    localparam int PENDING_W      = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd63;

    localparam logic [2:0] ST_RELEASED      = 3'd0;
    localparam logic [2:0] ST_LIMIT_ABORT   = 3'd1;
    localparam logic [2:0] ST_OUT_OF_WINDOW = 3'd2;
    localparam logic [2:0] ST_STALE         = 3'd3;
    localparam logic [2:0] ST_IGNORED       = 3'd4;

    typedef struct packed {
        logic [63:0] message_id;
        logic [15:0] payload_handle;
        logic [15:0] byte_count;
        logic        frame_end;
        logic        run_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] released_id;
        logic [15:0] released_handle;
        logic        released_frame_end;
        logic        released_run_end;
        logic        last;
        logic [31:0] frames_total;
        logic [31:0] messages_total;
        logic [47:0] bytes_total;
    } t_out_item;

    // Parked message body, one word per window slot.
    typedef struct packed {
        logic        run_end;
        logic        frame_end;
        logic [15:0] bytes;
        logic [15:0] handle;
    } t_slot;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic decide;
        logic drain;
        logic room;
    } t_ctl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic release_now;
        logic more;
    } t_dp_stat;

endpackage

/* rtl/mrb_ctrl.sv */
// Sequencer for the reorder buffer: accept, decide, drain.
module mrb_ctrl
    import mrb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [RES_CNT_W-1:0] r_cnt, n_cnt;
    logic [RES_CNT_W-1:0] cnt_after;
    logic                 room;

    assign busy      = (r_state != S_IDLE);
    assign cnt_after = (r_state == S_DECIDE) ? RES_CNT_W'(1) : r_cnt + RES_CNT_W'(1);
    assign room      = (cnt_after < RES_CNT_W'(MAX_RESULTS));

    assign o_cmd.load   = start && (r_state == S_IDLE);
    assign o_cmd.decide = (r_state == S_DECIDE);
    assign o_cmd.drain  = (r_state == S_DRAIN);
    assign o_cmd.room   = room;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_cnt = cnt_after;
                if (i_stat.release_now && i_stat.more && room) begin
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DRAIN: begin
                n_cnt = cnt_after;
                if (!(i_stat.more && room)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* rtl/mrb_datapath.sv */
// Reorder buffer datapath: sequence state, slot window, counters, result register.
module mrb_datapath
    import mrb_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl_cmd           i_cmd,
    output t_dp_stat           o_stat,
    input  t_in_item           i_item,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    output logic               o_strobe,
    output t_out_item          o_result
);

    localparam int IW = $clog2(WINDOW);
    localparam logic [IW-1:0] HEAD_LAST = IW'(WINDOW - 1);
    localparam logic [IW:0]   WIN_EXT   = (IW + 1)'(WINDOW);

    localparam logic [1:0] CLS_RELEASE = 2'd0;
    localparam logic [1:0] CLS_PARK    = 2'd1;
    localparam logic [1:0] CLS_STALE   = 2'd2;
    localparam logic [1:0] CLS_OOW     = 2'd3;

    t_in_item           r_in;
    logic               r_have_first, n_have_first;
    logic [63:0]        r_expected, n_expected;
    logic               r_stopped, n_stopped;
    logic [WINDOW-1:0]  r_valid, n_valid;
    logic [IW-1:0]      r_head, n_head;
    logic [PENDING_W-1:0] r_pending, n_pending;
    logic [31:0]        r_frames, n_frames;
    logic [31:0]        r_msgs, n_msgs;
    logic [47:0]        r_bytes, n_bytes;
    logic [LIMIT_W-1:0] r_limit;
    t_out_item          r_out, n_out;
    logic               r_strobe, n_strobe;

    t_slot              mem [WINDOW];
    t_slot              r_rd;
    logic               mem_we;

    logic [63:0]        diff;
    logic [1:0]         cls;
    logic [IW-1:0]      head_inc;
    logic [IW:0]        slot_sum;
    logic [IW-1:0]      slot_idx;
    logic [PENDING_W-1:0] pend_new;
    logic               abort;
    logic               more;

    logic               do_rel;
    logic [63:0]        rel_id;
    logic [15:0]        rel_handle;
    logic [15:0]        rel_bytes;
    logic               rel_fe;
    logic               rel_re;
    logic [48:0]        byte_sum;
    logic               do_single;
    logic [2:0]         single_st;

    // Distance of the arriving number ahead of the expected one.
    assign diff = r_have_first ? (r_in.message_id - r_expected) : '0;

    always_comb begin
        if (diff == '0) begin
            cls = CLS_RELEASE;
        end else if (diff[63]) begin
            cls = CLS_STALE;
        end else if (diff >= 64'(WINDOW)) begin
            cls = CLS_OOW;
        end else begin
            cls = CLS_PARK;
        end
    end

    assign head_inc = (r_head == HEAD_LAST) ? '0 : r_head + IW'(1);
    assign slot_sum = {1'b0, r_head} + {1'b0, diff[IW-1:0]};
    assign slot_idx = (slot_sum >= WIN_EXT) ? IW'(slot_sum - WIN_EXT) : slot_sum[IW-1:0];
    assign pend_new = r_pending + (r_valid[slot_idx] ? PENDING_W'(0) : PENDING_W'(1));
    assign abort    = (pend_new > PENDING_W'(r_limit));
    assign more     = r_valid[head_inc];

    assign o_stat.release_now = !r_stopped && (cls == CLS_RELEASE);
    assign o_stat.more        = more;

    assign do_rel = (i_cmd.decide && !r_stopped && (cls == CLS_RELEASE)) || i_cmd.drain;

    always_comb begin
        if (i_cmd.drain) begin
            rel_id     = r_expected;
            rel_handle = r_rd.handle;
            rel_bytes  = r_rd.bytes;
            rel_fe     = r_rd.frame_end;
            rel_re     = r_rd.run_end;
        end else begin
            rel_id     = r_in.message_id;
            rel_handle = r_in.payload_handle;
            rel_bytes  = r_in.byte_count;
            rel_fe     = r_in.frame_end;
            rel_re     = r_in.run_end;
        end
    end

    assign byte_sum = {1'b0, r_bytes} + 49'(rel_bytes);

    always_comb begin
        do_single = 1'b0;
        single_st = ST_IGNORED;
        if (i_cmd.decide) begin
            if (r_stopped) begin
                do_single = 1'b1;
                single_st = ST_IGNORED;
            end else begin
                case (cls)
                    CLS_STALE: begin
                        do_single = 1'b1;
                        single_st = ST_STALE;
                    end
                    CLS_OOW: begin
                        do_single = 1'b1;
                        single_st = ST_OUT_OF_WINDOW;
                    end
                    CLS_PARK: begin
                        do_single = abort;
                        single_st = ST_LIMIT_ABORT;
                    end
                    default: begin
                        do_single = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_have_first = r_have_first;
        n_expected   = r_expected;
        n_stopped    = r_stopped;
        n_valid      = r_valid;
        n_head       = r_head;
        n_pending    = r_pending;
        n_frames     = r_frames;
        n_msgs       = r_msgs;
        n_bytes      = r_bytes;
        n_out        = r_out;
        n_strobe     = 1'b0;
        mem_we       = 1'b0;

        if (i_cmd.decide && !r_stopped && (cls == CLS_PARK)) begin
            mem_we            = 1'b1;
            n_valid[slot_idx] = 1'b1;
            n_pending         = pend_new;
            if (abort) begin
                n_stopped = 1'b1;
            end
        end

        if (i_cmd.decide && !r_stopped && (cls == CLS_RELEASE)) begin
            n_have_first = 1'b1;
        end

        if (i_cmd.drain) begin
            n_valid[r_head] = 1'b0;
            if (r_pending != '0) begin
                n_pending = r_pending - PENDING_W'(1);
            end
        end

        if (do_rel) begin
            n_msgs  = (r_msgs == '1) ? r_msgs : r_msgs + 32'd1;
            n_bytes = byte_sum[48] ? '1 : byte_sum[47:0];
            if (rel_fe) begin
                n_frames = (r_frames == '1) ? r_frames : r_frames + 32'd1;
                if (rel_re) begin
                    n_stopped = 1'b1;
                end
            end
            n_expected = rel_id + 64'd1;
            n_head     = head_inc;
            n_strobe   = 1'b1;
            n_out.status             = ST_RELEASED;
            n_out.released_id        = rel_id;
            n_out.released_handle    = rel_handle;
            n_out.released_frame_end = rel_fe;
            n_out.released_run_end   = rel_re;
            n_out.last               = !(more && i_cmd.room);
            n_out.frames_total       = n_frames;
            n_out.messages_total     = n_msgs;
            n_out.bytes_total        = n_bytes;
        end else if (do_single) begin
            n_strobe = 1'b1;
            n_out.status             = single_st;
            n_out.released_id        = '0;
            n_out.released_handle    = '0;
            n_out.released_frame_end = 1'b0;
            n_out.released_run_end   = 1'b0;
            n_out.last               = 1'b1;
            n_out.frames_total       = r_frames;
            n_out.messages_total     = r_msgs;
            n_out.bytes_total        = r_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[slot_idx] <= '{run_end: r_in.run_end, frame_end: r_in.frame_end,
                               bytes: r_in.byte_count, handle: r_in.payload_handle};
        end
        r_rd <= mem[head_inc];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
        r_out <= n_out;
        if (!i_rst_n) begin
            r_expected <= '0;
            r_frames   <= '0;
            r_msgs     <= '0;
            r_bytes    <= '0;
        end else begin
            r_expected <= n_expected;
            r_frames   <= n_frames;
            r_msgs     <= n_msgs;
            r_bytes    <= n_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_stopped    <= 1'b0;
            r_valid      <= '0;
            r_head       <= '0;
            r_pending    <= '0;
            r_limit      <= LIMIT_RESET;
            r_strobe     <= 1'b0;
        end else begin
            r_have_first <= n_have_first;
            r_stopped    <= n_stopped;
            r_valid      <= n_valid;
            r_head       <= n_head;
            r_pending    <= n_pending;
            r_strobe     <= n_strobe;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

/* rtl/message_reorder_buffer.sv */
// Top level of the message reorder buffer: controller, datapath and checks.
//
// Usage:
//   Input: present a message on i_item and raise start; the message transfers
//   at the rising edge where start is high and busy is low.
//   Output: each result sits on o_result for exactly one cycle with o_strobe
//   high; the receiver takes it at the end of that cycle and cannot stall.
//   o_result.last marks the final result caused by a message. Parking an early
//   message in the window gives no result unless it trips the pending limit.
//   Config: i_cfg_we with i_cfg_wdata writes pending_limit (reset 63); write
//   it only while the block is idle.
// Timing:
//   A message is decided in the cycle after its transfer; its first result
//   appears in the cycle after that. Busy is high while the block decides and
//   drains, so it takes no new message until it is done with the last one.
//   A release that uncovers parked successors adds one drain step per drained
//   slot (one slot-memory read per cycle), up to 64 results per message.
// Reset: synchronous, active low; clears the sequence, slot valid bits,
//   counters and the stop flag. Slot contents are not cleared.
module message_reorder_buffer
    import mrb_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_item           i_item,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    output logic               o_strobe,
    output t_out_item          o_result
);

    t_ctl_cmd cmd;
    t_dp_stat stat;

    // Sequencer: hold the item through decide, then drain parked successors.
    mrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Datapath: classify against the expected number, park, release, count.
    mrb_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // A transfer always starts the decide cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not start processing");

    // Every non-release result is the only result of its message.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != ST_RELEASED)) |-> o_result.last)
        else $error("non-release result not marked last");

    // A drain step only follows a decide or another drain step.
    a_drain_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.drain |-> $past(cmd.decide || cmd.drain))
        else $error("drain step without a release");

    // A result that is not last is followed by another in the next cycle.
    a_drain_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("gap inside a drain burst");

endmodule

/* bench/tb_message_reorder_buffer.sv */
// Self-checking testbench for the message reorder buffer: release order, parking and stop rules.
module tb_message_reorder_buffer
    import mrb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN    = WINDOW_DEFAULT;
    // Cycles to let the block finish deciding a message that gives no result.
    localparam int SETTLE = 8;

    // ------------------------------------------------------------------
    // Release tracker: mirrors the window, sequence and counters, and holds
    // the results the block owes us in the order they must appear.
    // ------------------------------------------------------------------
    class release_checker;
        bit                 have_first;
        logic [63:0]        next_id;
        bit                 stopped;
        bit                 slot_used [WIN];
        t_slot              slot_body [WIN];
        int unsigned        parked;
        int unsigned        head;
        logic [LIMIT_W-1:0] limit;
        logic [31:0]        frames;
        logic [31:0]        msgs;
        logic [47:0]        byte_sum;
        t_out_item          due_results [$];
        int unsigned        faults;

        function new();
            have_first = 1'b0;
            next_id    = '0;
            stopped    = 1'b0;
            parked     = 0;
            head       = 0;
            limit      = LIMIT_RESET;
            frames     = '0;
            msgs       = '0;
            byte_sum   = '0;
            faults     = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function t_out_item blank(logic [2:0] st);
            t_out_item r;
            r                = '0;
            r.status         = st;
            r.frames_total   = frames;
            r.messages_total = msgs;
            r.bytes_total    = byte_sum;
            return r;
        endfunction

        function void flag_only(logic [2:0] st);
            t_out_item r;
            r      = blank(st);
            r.last = 1'b1;
            due_results.push_back(r);
        endfunction

        // Release the message at the head of the sequence and advance it.
        function void release_one(t_slot body);
            t_out_item r;
            if (msgs != '1) msgs++;
            if (48'hFFFF_FFFF_FFFF - byte_sum < body.bytes) byte_sum = '1;
            else byte_sum += body.bytes;
            if (body.frame_end) begin
                if (frames != '1) frames++;
                if (body.run_end) stopped = 1'b1;
            end
            r                    = blank(ST_RELEASED);
            r.released_id        = next_id;
            r.released_handle    = body.handle;
            r.released_frame_end = body.frame_end;
            r.released_run_end   = body.run_end;
            due_results.push_back(r);
            next_id++;
            head = (head + 1) % WIN;
        endfunction

        function void note_message(t_in_item m);
            logic [63:0] d;
            int unsigned s;
            int          n;
            t_slot       body;
            t_out_item   r;
            body.handle    = m.payload_handle;
            body.bytes     = m.byte_count;
            body.frame_end = m.frame_end;
            body.run_end   = m.run_end;
            if (stopped) begin
                flag_only(ST_IGNORED);
                return;
            end
            if (!have_first) begin
                have_first = 1'b1;
                next_id    = m.message_id;
            end
            d = m.message_id - next_id;
            if (d != 0) begin
                if (d[63]) begin
                    flag_only(ST_STALE);
                    return;
                end
                if (d >= WIN) begin
                    flag_only(ST_OUT_OF_WINDOW);
                    return;
                end
                s = (head + int'(d[7:0])) % WIN;
                if (!slot_used[s]) begin
                    slot_used[s] = 1'b1;
                    parked++;
                end
                slot_body[s] = body;
                if (parked > limit) begin
                    stopped = 1'b1;
                    flag_only(ST_LIMIT_ABORT);
                end
                return;
            end
            release_one(body);
            n = 1;
            while (n < MAX_RESULTS && slot_used[head]) begin
                slot_used[head] = 1'b0;
                if (parked > 0) parked--;
                release_one(slot_body[head]);
                n++;
            end
            r      = due_results.pop_back();
            r.last = 1'b1;
            due_results.push_back(r);
        endfunction

        function string show(t_out_item r);
            return $sformatf("st=%0d id=%h h=%h fe=%b re=%b last=%b fr=%0d msg=%0d by=%0d",
                             r.status, r.released_id, r.released_handle,
                             r.released_frame_end, r.released_run_end, r.last,
                             r.frames_total, r.messages_total, r.bytes_total);
        endfunction

        function void complain(string what, string want, string got);
            faults++;
            if (faults <= 10)
                $display("%0t %s\n  expected %s\n  actual   %s", $realtime, what, want, got);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                complain("result with nothing outstanding", "none", show(got));
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status
                    || got.released_id !== want.released_id
                    || got.released_handle !== want.released_handle
                    || got.released_frame_end !== want.released_frame_end
                    || got.released_run_end !== want.released_run_end
                    || got.last !== want.last
                    || got.frames_total !== want.frames_total
                    || got.messages_total !== want.messages_total
                    || got.bytes_total !== want.bytes_total)
                complain("result differs", show(want), show(got));
        endfunction

        function void leftovers();
            if (due_results.size() != 0)
                complain($sformatf("%0d results never came", due_results.size()),
                         show(due_results[0]), "none");
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero.
    // ------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n  = 1'b0;
    logic               start    = 1'b0;
    logic               busy;
    t_in_item           msg_in   = '0;
    logic               cfg_we   = 1'b0;
    logic [LIMIT_W-1:0] cfg_data = '0;
    logic               res_strobe;
    t_out_item          res_item;

    release_checker sb = new();
    int unsigned    items_sent = 0;
    int unsigned    burst_left = 1;
    int unsigned    offs [WIN];

    message_reorder_buffer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (msg_in),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_data),
        .o_strobe    (res_strobe),
        .o_result    (res_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Take every strobed result at the edge that ends its cycle; the block
    // cannot be held off, so there is nothing to drive on this side.
    always @(posedge i_clk) begin
        if (i_rst_n && res_strobe) sb.check_result(res_item);
    end

    // Hard stop in case a transfer never completes or results stop flowing.
    initial begin
        #2_000_000;
        $display("message_reorder_buffer: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic t_in_item make(logic [63:0] id, logic [15:0] h, logic [15:0] b,
                                      logic fe, logic re);
        t_in_item m;
        m.message_id     = id;
        m.payload_handle = h;
        m.byte_count     = b;
        m.frame_end      = fe;
        m.run_end        = re;
        return m;
    endfunction

    // Drop start for a few cycles; a zero-length pause touches nothing.
    task automatic pause(int unsigned n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Present one message, hold it until the transfer, then note it. Start
    // stays high so the next message of a burst follows without a gap.
    task automatic push_message(t_in_item m);
        start  <= 1'b1;
        msg_in <= m;
        do @(posedge i_clk); while (busy);
        sb.note_message(m);
        items_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            pause($urandom_range(1, 8));
            // Now and then a long burst with no idling at all.
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
        end
    endtask

    // Hold the sender off until every owed result has been seen, then let
    // the block finish any message that parks silently.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sb.limit  = v;
    endtask

    // Send a message with random content for the given number. Redirect a
    // park that would trip the pending limit to the expected number, and
    // keep the frame-end/run-end pair off anything that can be released.
    task automatic offer(logic [63:0] id);
        t_in_item    m;
        logic [63:0] d;
        int unsigned s;
        int unsigned grow;
        m = make(id, 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        d = id - sb.next_id;
        if (sb.have_first && d != 0 && !d[63] && d < WIN) begin
            s    = (sb.head + int'(d[7:0])) % WIN;
            grow = sb.slot_used[s] ? 0 : 1;
            if (sb.parked + grow > sb.limit) m.message_id = sb.next_id;
        end
        d = m.message_id - sb.next_id;
        if (!sb.have_first || d == 0 || (!d[63] && d < WIN))
            m.run_end = m.run_end & ~m.frame_end;
        push_message(m);
    endtask

    // Stale or out-of-window numbers, boundaries included.
    task automatic offer_noise();
        logic [63:0] r;
        logic [63:0] d;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       d = 64'(WIN);
            1:       d = 64'h7FFF_FFFF_FFFF_FFFF;
            2:       d = 64'h8000_0000_0000_0000;
            3:       d = '1;
            4:       d = {1'b1, r[62:0]};
            default: d = {1'b0, r[62:0]};
        endcase
        if (!d[63] && d < WIN) d += WIN;
        offer(sb.next_id + d);
    endtask

    function automatic void shuffle_offs(int unsigned k);
        int unsigned j;
        int unsigned t;
        for (int unsigned i = 0; i < k; i++) offs[i] = i;
        for (int unsigned i = k - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = offs[i];
            offs[i] = offs[j];
            offs[j] = t;
        end
    endfunction

    // Release in order until nothing is parked.
    task automatic flush();
        while (sb.parked != 0) offer(sb.next_id);
    endtask

    // Change the limit only with the block idle and nothing parked.
    task automatic retune(logic [LIMIT_W-1:0] v);
        wait_drained();
        flush();
        wait_drained();
        write_limit(v);
    endtask

    task automatic run_directed();
        logic [63:0] n;
        // First message sets the sequence just below the wrap point.
        push_message(make(64'hFFFF_FFFF_FFFF_FFFE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
        // Run end alone must not stop; the expected number wraps to zero.
        push_message(make(sb.next_id, 16'h0000, 16'h0000, 1'b0, 1'b1));
        // Stale and out-of-window edges; the stop pair here changes nothing.
        push_message(make(sb.next_id - 1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        push_message(make(sb.next_id + 64'h8000_0000_0000_0000, 16'h5A5A, 16'hA5A5, 1'b1, 1'b1));
        push_message(make(sb.next_id + 64'h7FFF_FFFF_FFFF_FFFF, 16'hA5A5, 16'h5A5A, 1'b0, 1'b1));
        push_message(make(sb.next_id + WIN, 16'h0F0F, 16'hF0F0, 1'b1, 1'b0));
        // Park at the far edge, park twice at one number, then release a chain.
        n = sb.next_id;
        push_message(make(n + WIN - 1, 16'h1234, 16'h0010, 1'b1, 1'b0));
        push_message(make(n + 2, 16'h2222, 16'h0020, 1'b0, 1'b1));
        push_message(make(n + 2, 16'h3333, 16'h0030, 1'b1, 1'b0));
        push_message(make(n + 1, 16'h4444, 16'h0040, 1'b0, 1'b0));
        push_message(make(n, 16'h5555, 16'h0050, 1'b0, 1'b0));
        repeat (4) offer(sb.next_id);
        n = sb.next_id;
        push_message(make(n + 1, 16'h6666, 16'hFFFF, 1'b0, 1'b1));
        push_message(make(n, 16'h7777, 16'h0000, 1'b1, 1'b0));
    endtask

    task automatic run_random(int unsigned count);
        int unsigned stop_at;
        int unsigned kind;
        int unsigned k;
        logic [63:0] base;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                // In-order run: the common case.
                repeat ($urandom_range(1, 8)) offer(sb.next_id);
            end else if (kind < 70) begin
                // Short shuffled block, now and then with a repeated number.
                k    = $urandom_range(2, 8);
                base = sb.next_id;
                shuffle_offs(k);
                for (int unsigned i = 0; i < k; i++) begin
                    offer(base + offs[i]);
                    if ($urandom_range(0, 5) == 0) offer(base + offs[i]);
                end
            end else if (kind < 80) begin
                offer_noise();
            end else if (kind < 90) begin
                offer(sb.next_id + $urandom_range(1, WIN - 1));
            end else if (kind < 93) begin
                offer(sb.next_id + WIN - 1);
            end else if (kind < 96 && sb.limit == LIMIT_RESET) begin
                // Fill the whole window, then release it in one long drain.
                base = sb.next_id;
                shuffle_offs(WIN - 1);
                for (int unsigned i = 0; i < WIN - 1; i++) offer(base + 1 + offs[i]);
                offer(base);
            end else if (kind < 98) begin
                wait_drained();
            end else begin
                offer(sb.next_id);
            end
        end
    endtask

    // Stop the block one of two ways, then show that it ignores the rest.
    task automatic run_ending();
        logic [63:0] n;
        int unsigned lim;
        if ($urandom_range(0, 1) == 0) begin
            // Park one message more than the limit allows.
            lim = $urandom_range(1, 8);
            retune(LIMIT_W'(lim));
            n = sb.next_id;
            for (int unsigned i = 1; i <= lim + 1; i++)
                push_message(make(n + i, 16'($urandom), 16'($urandom), 1'b0, 1'b0));
        end else begin
            // End of run met mid-drain; the rest of the drain still comes out.
            retune(LIMIT_RESET);
            n = sb.next_id;
            push_message(make(n + 2, 16'($urandom), 16'($urandom), 1'b0, 1'b0));
            push_message(make(n + 1, 16'($urandom), 16'($urandom), 1'b1, 1'b1));
            push_message(make(n, 16'($urandom), 16'($urandom), 1'b0, 1'b0));
        end
        repeat (3)
            push_message(make({$urandom, $urandom}, 16'($urandom), 16'($urandom),
                              1'($urandom), 1'($urandom)));
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_limit(LIMIT_RESET);
        run_directed();
        run_random(80);
        // Limit of one: at most one message parked at a time.
        retune(LIMIT_W'(1));
        run_random(40);
        retune(LIMIT_W'($urandom_range(2, 62)));
        run_random(40);
        retune(LIMIT_RESET);
        run_random(40);
        run_ending();
        wait_drained();
        repeat (16) @(posedge i_clk);
        sb.leftovers();
        if (sb.faults == 0) begin
            $display("message_reorder_buffer: match");
        end else begin
            $display("message_reorder_buffer: mismatch");
        end
        $finish;
    end

endmodule
